// ===== hw/rtl/bst_pkg.sv =====
// Shared constants for the bit-serial transceiver: phase codes, register indexes, reset values.
`default_nettype none
package bst_pkg;

   // Frame phase codes, shared by the receive and transmit sequencers
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_START = 2'd1;
   localparam logic [1:0] PH_DATA  = 2'd2;
   localparam logic [1:0] PH_STOP  = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RX_BIT_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TX_BIT_TICKS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RX_FIRST_TICKS = 2'd2;

   // Field widths fixed by the interface
   localparam int unsigned TICK_W    = 8;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned RX_DATA_W = 16;

   // Register reset values
   localparam logic [TICK_W-1:0] RX_BIT_TICKS_RST   = 8'd137;
   localparam logic [TICK_W-1:0] TX_BIT_TICKS_RST   = 8'd138;
   localparam logic [TICK_W-1:0] RX_FIRST_TICKS_RST = 8'd20;

endpackage
`default_nettype wire

// ===== hw/rtl/bit_serial_transceiver.sv =====
// Tick-driven bit-timed serial receiver and transmitter with an output register.
//
// Each req_ item is one timer tick: the sampled receive line level, plus an
// optional transmit request with its byte. Every accepted item yields exactly
// one rsp_ item: the transmit line level, transmitter busy, and on the tick a
// received frame's stop bit is sampled, rx_valid with the word and frame error.
// error_latched is sticky until reset.
// An item's result is registered and is on rsp_ the cycle after acceptance.
// Throughput is one item per cycle unless req_stall is high; receive and
// transmit phase counters are updated in the accept cycle, the result lands
// in the output register, and a new item enters while the last is taken.
// When the receiver stalls with a result pending, req_stall rises in the same
// cycle and the result holds until taken; no ticks are lost or duplicated,
// since the timing state only advances on accepted items.
// Configuration (csr_) must be written only while idle; the block does not
// enforce this. Register values of 0 behave like 1. Reset (synchronous)
// restores the register defaults, puts both sequencers in idle with the
// transmit line high, and empties the output register.
`default_nettype none
module bit_serial_transceiver
   import bst_pkg::*;
#(
   parameter int unsigned RX_BITS = 16,
   parameter int unsigned TX_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration write port
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]      csr_wdata,
   // tick items in
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_line_in,
   input  wire logic                   req_tx_start,
   input  wire logic [BYTE_W-1:0]      req_tx_byte,
   // result items out
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_line_out,
   output logic                        rsp_tx_busy,
   output logic                        rsp_rx_valid,
   output logic [RX_DATA_W-1:0]        rsp_rx_data,
   output logic                        rsp_rx_frame_error,
   output logic                        rsp_error_latched
);

   localparam int unsigned RX_IDX_W = $clog2(RX_BITS + 1);
   localparam int unsigned TX_IDX_W = $clog2(TX_BITS + 1);
   localparam int unsigned RX_OUT_W = (RX_BITS < RX_DATA_W) ? RX_BITS : RX_DATA_W;

   // configuration registers
   logic [TICK_W-1:0] rx_bit_ticks_ff;
   logic [TICK_W-1:0] tx_bit_ticks_ff;
   logic [TICK_W-1:0] rx_first_ticks_ff;

   // receive state
   logic [1:0]          rx_phase_ff, rx_phase_in;
   logic [TICK_W-1:0]   rx_count_ff, rx_count_in;
   logic [RX_BITS-1:0]  rx_shift_ff, rx_shift_in;
   logic [RX_IDX_W-1:0] rx_index_ff, rx_index_in;
   logic                rx_start_bad_ff, rx_start_bad_in;
   logic                error_ff, error_in;

   // transmit state
   logic [1:0]          tx_phase_ff, tx_phase_in;
   logic [TICK_W-1:0]   tx_count_ff, tx_count_in;
   logic [TX_BITS-1:0]  tx_shift_ff, tx_shift_in;
   logic [TX_IDX_W-1:0] tx_index_ff, tx_index_in;
   logic                line_level_ff, line_level_in;

   // output register
   logic                 out_valid_ff;
   logic                 out_line_ff;
   logic                 out_busy_ff;
   logic                 out_rx_valid_ff, out_rx_valid_in;
   logic [RX_DATA_W-1:0] out_rx_data_ff, out_rx_data_in;
   logic                 out_ferr_ff, out_ferr_in;
   logic                 out_err_ff;

   logic                  accept;
   logic [TICK_W-1:0]     rx_count_inc;
   logic [RX_IDX_W-1:0]   rx_index_inc;
   logic                  ferr;

   // handshake: take a new item unless a result is stuck in the output register
   assign req_stall = out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // configuration writes; other indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_bit_ticks_ff   <= RX_BIT_TICKS_RST;
         tx_bit_ticks_ff   <= TX_BIT_TICKS_RST;
         rx_first_ticks_ff <= RX_FIRST_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RX_BIT_TICKS:   rx_bit_ticks_ff   <= csr_wdata;
            CSR_TX_BIT_TICKS:   tx_bit_ticks_ff   <= csr_wdata;
            CSR_RX_FIRST_TICKS: rx_first_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // receive sequencer
   assign rx_count_inc = rx_count_ff + TICK_W'(1);
   assign rx_index_inc = rx_index_ff + RX_IDX_W'(1);
   assign ferr         = rx_start_bad_ff | ~req_line_in;

   always_comb begin
      rx_phase_in     = rx_phase_ff;
      rx_count_in     = rx_count_ff;
      rx_shift_in     = rx_shift_ff;
      rx_index_in     = rx_index_ff;
      rx_start_bad_in = rx_start_bad_ff;
      error_in        = error_ff;
      out_rx_valid_in = 1'b0;
      out_rx_data_in  = '0;
      out_ferr_in     = 1'b0;
      unique case (rx_phase_ff)
         PH_IDLE: begin
            // low line is the start edge; this tick is tick zero
            if (!req_line_in) begin
               rx_phase_in     = PH_START;
               rx_count_in     = '0;
               rx_shift_in     = '0;
               rx_index_in     = '0;
               rx_start_bad_in = 1'b0;
            end
         end
         PH_START: begin
            rx_count_in = rx_count_inc;
            if (rx_count_inc >= rx_first_ticks_ff) begin
               rx_start_bad_in = req_line_in;
               rx_count_in     = '0;
               rx_index_in     = '0;
               rx_phase_in     = PH_DATA;
            end
         end
         PH_DATA: begin
            rx_count_in = rx_count_inc;
            if (rx_count_inc >= rx_bit_ticks_ff) begin
               rx_count_in              = '0;
               rx_shift_in              = rx_shift_ff >> 1;
               rx_shift_in[RX_BITS-1]   = req_line_in;
               rx_index_in              = rx_index_inc;
               if (rx_index_inc >= RX_IDX_W'(RX_BITS)) begin
                  rx_phase_in = PH_STOP;
               end
            end
         end
         default: begin
            // stop bit sample completes the frame
            rx_count_in = rx_count_inc;
            if (rx_count_inc >= rx_bit_ticks_ff) begin
               rx_count_in     = '0;
               out_rx_valid_in = 1'b1;
               out_rx_data_in  = RX_DATA_W'(rx_shift_ff[RX_OUT_W-1:0]);
               out_ferr_in     = ferr;
               error_in        = error_ff | ferr;
               rx_phase_in     = PH_IDLE;
            end
         end
      endcase
   end

   // transmit sequencer; the accepting tick already drives the start bit
   always_comb begin
      tx_phase_in   = tx_phase_ff;
      tx_count_in   = tx_count_ff;
      tx_shift_in   = tx_shift_ff;
      tx_index_in   = tx_index_ff;
      line_level_in = line_level_ff;
      if (tx_phase_ff == PH_IDLE) begin
         if (req_tx_start) begin
            tx_shift_in   = TX_BITS'(req_tx_byte);
            tx_phase_in   = PH_START;
            tx_count_in   = TICK_W'(1);
            tx_index_in   = '0;
            line_level_in = 1'b0;
         end
      end else if (tx_count_ff < tx_bit_ticks_ff) begin
         tx_count_in = tx_count_ff + TICK_W'(1);
      end else begin
         tx_count_in = TICK_W'(1);
         unique case (tx_phase_ff)
            PH_START: begin
               tx_phase_in   = PH_DATA;
               tx_index_in   = '0;
               line_level_in = tx_shift_ff[0];
               tx_shift_in   = tx_shift_ff >> 1;
            end
            PH_DATA: begin
               tx_index_in = tx_index_ff + TX_IDX_W'(1);
               if (tx_index_in < TX_IDX_W'(TX_BITS)) begin
                  line_level_in = tx_shift_ff[0];
                  tx_shift_in   = tx_shift_ff >> 1;
               end else begin
                  tx_phase_in   = PH_STOP;
                  line_level_in = 1'b1;
               end
            end
            default: begin
               tx_phase_in   = PH_IDLE;
               tx_count_in   = '0;
               tx_index_in   = '0;
               line_level_in = 1'b1;
            end
         endcase
      end
   end

   // state update on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_phase_ff     <= PH_IDLE;
         rx_count_ff     <= '0;
         rx_shift_ff     <= '0;
         rx_index_ff     <= '0;
         rx_start_bad_ff <= 1'b0;
         error_ff        <= 1'b0;
         tx_phase_ff     <= PH_IDLE;
         tx_count_ff     <= '0;
         tx_shift_ff     <= '0;
         tx_index_ff     <= '0;
         line_level_ff   <= 1'b1;
      end else if (accept) begin
         rx_phase_ff     <= rx_phase_in;
         rx_count_ff     <= rx_count_in;
         rx_shift_ff     <= rx_shift_in;
         rx_index_ff     <= rx_index_in;
         rx_start_bad_ff <= rx_start_bad_in;
         error_ff        <= error_in;
         tx_phase_ff     <= tx_phase_in;
         tx_count_ff     <= tx_count_in;
         tx_shift_ff     <= tx_shift_in;
         tx_index_ff     <= tx_index_in;
         line_level_ff   <= line_level_in;
      end
   end

   // output register: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output register: payload
   always_ff @(posedge clock) begin
      if (accept) begin
         out_line_ff     <= line_level_in;
         out_busy_ff     <= (tx_phase_in != PH_IDLE);
         out_rx_valid_ff <= out_rx_valid_in;
         out_rx_data_ff  <= out_rx_data_in;
         out_ferr_ff     <= out_ferr_in;
         out_err_ff      <= error_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_line_out       = out_line_ff;
   assign rsp_tx_busy        = out_busy_ff;
   assign rsp_rx_valid       = out_rx_valid_ff;
   assign rsp_rx_data        = out_rx_data_ff;
   assign rsp_rx_frame_error = out_ferr_ff;
   assign rsp_error_latched  = out_err_ff;

   // checks
   a_ferr_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_frame_error |-> rsp_rx_valid)
      else $error("frame error reported without a completed frame");

   a_ferr_sets_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_frame_error |-> rsp_error_latched)
      else $error("frame error not reflected in sticky flag");

   a_idle_line_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_busy |-> rsp_line_out)
      else $error("transmit line low while transmitter idle");

   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      $past(error_ff) && !$past(reset) |-> error_ff)
      else $error("sticky error flag cleared without reset");

endmodule
`default_nettype wire

// ===== tb/bit_serial_transceiver_tb.sv =====
// Self-checking testbench for bit_serial_transceiver: tick stream in, line status out.
`timescale 1ns / 100ps

module bit_serial_transceiver_tb
   import bst_pkg::*;
;

   localparam int RX_WORD_BITS = RX_DATA_W;
   localparam int TX_WORD_BITS = BYTE_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;  // no register behind it
   localparam int NUM_PHASES = 10;
   localparam int LONG_HOLD = 60;
   localparam int unsigned CYCLE_LIMIT = 200000;

   // One result item per tick
   typedef struct packed {
      logic                 line_out;
      logic                 tx_busy;
      logic                 rx_valid;
      logic [RX_DATA_W-1:0] rx_data;
      logic                 frame_error;
      logic                 err_latched;
   } status_type;

   localparam status_type ST_IDLE     = '{1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
   localparam status_type ST_TX_START = '{1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0};

   // Directed stimulus: a register write or one tick
   typedef struct {
      bit                     is_write;
      logic [CSR_INDEX_W-1:0] addr;
      logic [TICK_W-1:0]      wdata;
      bit                     line;
      bit                     start;
      logic [BYTE_W-1:0]      tx_data;
      bit                     typed;
      status_type             want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TICK_W-1:0]      csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_line_in = 1'b1;
   logic                   req_tx_start = 1'b0;
   logic [BYTE_W-1:0]      req_tx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_line_out;
   logic                   rsp_tx_busy;
   logic                   rsp_rx_valid;
   logic [RX_DATA_W-1:0]   rsp_rx_data;
   logic                   rsp_rx_frame_error;
   logic                   rsp_error_latched;

   status_type  pending_status[$];
   int          failures = 0;
   int          gap_pct = 0;
   int          stall_pct = 0;
   bit          hold_off_pending = 1'b0;
   int unsigned cycle_count = 0;

   // Register copies
   logic [TICK_W-1:0] cfg_rx_bit = RX_BIT_TICKS_RST;
   logic [TICK_W-1:0] cfg_tx_bit = TX_BIT_TICKS_RST;
   logic [TICK_W-1:0] cfg_first  = RX_FIRST_TICKS_RST;

   // Receiver and transmitter state as the block should hold it
   logic [1:0]           rx_ph = PH_IDLE;
   logic [TICK_W-1:0]    rx_cnt = '0;
   logic [RX_DATA_W-1:0] rx_sh = '0;
   int                   rx_idx = 0;
   logic                 rx_start_bad = 1'b0;
   logic                 sticky_err = 1'b0;
   logic [1:0]           tx_ph = PH_IDLE;
   logic [TICK_W-1:0]    tx_cnt = '0;
   logic [BYTE_W-1:0]    tx_sh = '0;
   int                   tx_idx = 0;
   logic                 line_lvl = 1'b1;

   stim_row_type directed_rows [26] = '{
      '{1'b0, '0, '0, 1'b1, 1'b0, 8'h00, 1'b1, ST_IDLE},
      '{1'b0, '0, '0, 1'b1, 1'b1, 8'hFF, 1'b1, ST_TX_START},
      // start request while busy is dropped
      '{1'b0, '0, '0, 1'b1, 1'b1, 8'h00, 1'b1, ST_TX_START},
      '{1'b1, CSR_UNUSED,         8'h01, 1'b1, 1'b0, 8'h00, 1'b0, '0},
      // zero tick registers behave like one
      '{1'b1, CSR_RX_BIT_TICKS,   8'h00, 1'b1, 1'b0, 8'h00, 1'b0, '0},
      '{1'b1, CSR_TX_BIT_TICKS,   8'h00, 1'b1, 1'b0, 8'h00, 1'b0, '0},
      '{1'b1, CSR_RX_FIRST_TICKS, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, '0},
      // start edge, then start sample
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b1, 8'h33, 1'b0, '0},
      // data word 0x8001, LSB first
      '{1'b0, '0, '0, 1'b1, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      // transmitter leaves its stop bit here: request is still dropped
      '{1'b0, '0, '0, 1'b0, 1'b1, 8'h5A, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b1, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
      '{1'b0, '0, '0, 1'b1, 1'b0, 8'h00, 1'b0, '0},
      // low stop bit: frame error, latch sets
      '{1'b0, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0, '0}
   };

   bit_serial_transceiver #(
      .RX_BITS(RX_WORD_BITS),
      .TX_BITS(TX_WORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_line_in(req_line_in),
      .req_tx_start(req_tx_start),
      .req_tx_byte(req_tx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_line_out(rsp_line_out),
      .rsp_tx_busy(rsp_tx_busy),
      .rsp_rx_valid(rsp_rx_valid),
      .rsp_rx_data(rsp_rx_data),
      .rsp_rx_frame_error(rsp_rx_frame_error),
      .rsp_error_latched(rsp_error_latched)
   );

   always #5 clock = ~clock;

   // Advance receiver and transmitter by one tick and return the line status
   function automatic status_type step_transceiver(input bit line, input bit start,
                                                   input logic [BYTE_W-1:0] tx_data);
      status_type s;
      s = '0;
      // receiver
      if (rx_ph == PH_IDLE) begin
         if (!line) begin
            rx_ph = PH_START;
            rx_cnt = '0;
            rx_sh = '0;
            rx_idx = 0;
            rx_start_bad = 1'b0;
         end
      end else begin
         rx_cnt = rx_cnt + TICK_W'(1);
         case (rx_ph)
            PH_START: begin
               if (rx_cnt >= cfg_first) begin
                  rx_start_bad = line;
                  rx_cnt = '0;
                  rx_idx = 0;
                  rx_ph = PH_DATA;
               end
            end
            PH_DATA: begin
               if (rx_cnt >= cfg_rx_bit) begin
                  rx_cnt = '0;
                  rx_sh = {line, rx_sh[RX_DATA_W-1:1]};
                  rx_idx++;
                  if (rx_idx >= RX_WORD_BITS) rx_ph = PH_STOP;
               end
            end
            default: begin
               if (rx_cnt >= cfg_rx_bit) begin
                  rx_cnt = '0;
                  s.rx_valid = 1'b1;
                  s.rx_data = rx_sh;
                  s.frame_error = rx_start_bad | ~line;
                  sticky_err = sticky_err | s.frame_error;
                  rx_ph = PH_IDLE;
               end
            end
         endcase
      end
      // transmitter; the acceptance tick already drives the start bit
      if (tx_ph == PH_IDLE) begin
         if (start) begin
            tx_sh = tx_data;
            tx_ph = PH_START;
            tx_cnt = TICK_W'(1);
            tx_idx = 0;
            line_lvl = 1'b0;
         end
      end else if (tx_cnt < cfg_tx_bit) begin
         tx_cnt = tx_cnt + TICK_W'(1);
      end else begin
         tx_cnt = TICK_W'(1);
         case (tx_ph)
            PH_START: begin
               tx_ph = PH_DATA;
               tx_idx = 0;
               line_lvl = tx_sh[0];
               tx_sh = tx_sh >> 1;
            end
            PH_DATA: begin
               tx_idx++;
               if (tx_idx < TX_WORD_BITS) begin
                  line_lvl = tx_sh[0];
                  tx_sh = tx_sh >> 1;
               end else begin
                  tx_ph = PH_STOP;
                  line_lvl = 1'b1;
               end
            end
            default: begin
               tx_ph = PH_IDLE;
               tx_cnt = '0;
               tx_idx = 0;
               line_lvl = 1'b1;
            end
         endcase
      end
      s.line_out = line_lvl;
      s.tx_busy = (tx_ph != PH_IDLE);
      s.err_latched = sticky_err;
      return s;
   endfunction

   // Tick register value for a random phase: mostly short, sometimes zero or longer
   function automatic logic [TICK_W-1:0] pick_ticks();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return TICK_W'($urandom_range(40, 7));
      return TICK_W'($urandom_range(6, 1));
   endfunction

   function automatic void check_field(input string field, input logic [RX_DATA_W-1:0] want,
                                       input logic [RX_DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         failures++;
      end
   endfunction

   // Stop offering ticks until every outstanding status has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] addr,
                            input logic [TICK_W-1:0] value);
      drain();
      csr_we <= 1'b1;
      csr_index <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         CSR_RX_BIT_TICKS:   cfg_rx_bit = value;
         CSR_TX_BIT_TICKS:   cfg_tx_bit = value;
         CSR_RX_FIRST_TICKS: cfg_first = value;
         default: ;
      endcase
   endtask

   // Offer one tick, wait for acceptance, record what it should produce
   task automatic send_tick(input bit line, input bit start, input logic [BYTE_W-1:0] tx_data,
                            input bit typed, input status_type want);
      status_type predicted;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_line_in <= line;
      req_tx_start <= start;
      req_tx_byte <= tx_data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = step_transceiver(line, start, tx_data);
      pending_status.push_back(typed ? want : predicted);
   endtask

   // Stimulus
   initial begin : tick_source
      bit                   line_plan[$];
      logic [RX_DATA_W-1:0] word;
      logic [TICK_W-1:0]    rxb, txb, fst;
      int                   f, b, n_items;
      bit                   lvl, stop_level;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            write_csr(directed_rows[i].addr, directed_rows[i].wdata);
         end else begin
            send_tick(directed_rows[i].line, directed_rows[i].start, directed_rows[i].tx_data,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 0) begin
            rxb = 8'd1;
            txb = 8'd1;
            fst = 8'd1;
         end else if (ph == 1) begin
            rxb = 8'd255;
            txb = 8'd255;
            fst = 8'd255;
         end else begin
            rxb = pick_ticks();
            txb = pick_ticks();
            fst = pick_ticks();
         end
         write_csr(CSR_RX_BIT_TICKS, rxb);
         write_csr(CSR_TX_BIT_TICKS, txb);
         write_csr(CSR_RX_FIRST_TICKS, fst);
         f = (cfg_first == 0) ? 1 : int'(cfg_first);
         b = (cfg_rx_bit == 0) ? 1 : int'(cfg_rx_bit);
         n_items = (ph == 1) ? 520 : 150;
         // no idling at all in the closing phase
         gap_pct = (ph == NUM_PHASES - 1 || ph % 3 == 2) ? 0 : 20;
         stall_pct = (ph == NUM_PHASES - 1 || ph % 4 == 0) ? 0 : 25;
         line_plan.delete();

         for (int n = 0; n < n_items; n++) begin
            if (ph == 3 && n == 75) hold_off_pending = 1'b1;
            if (ph == 5 && n == 75) drain();
            // refill with a noise burst or a frame timed to the current registers
            if (line_plan.size() == 0) begin
               if ($urandom_range(7) == 0) begin
                  repeat ($urandom_range(20, 1)) line_plan.push_back(1'($urandom_range(1)));
               end else begin
                  word = RX_DATA_W'($urandom);
                  stop_level = ($urandom_range(5) != 0);
                  repeat ($urandom_range(3)) line_plan.push_back(1'b1);
                  repeat (f) line_plan.push_back(1'b0);
                  // start sample, high now and then
                  line_plan.push_back($urandom_range(9) == 0);
                  for (int k = 0; k < RX_WORD_BITS; k++) begin
                     repeat (b) line_plan.push_back(word[k]);
                  end
                  repeat (b) line_plan.push_back(stop_level);
               end
            end
            lvl = line_plan.pop_front();
            send_tick(lvl, $urandom_range(3) == 0, BYTE_W'($urandom_range(255)), 1'b0, '0);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (failures == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   // Result side backpressure: short random bursts, one long hold on request
   initial begin : rsp_backpressure
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_pending = 1'b0;
         end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(5, 1)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result with the oldest outstanding status
   always @(posedge clock) begin : status_check
      status_type oldest;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $error("rsp item with no tick outstanding");
            failures++;
         end else begin
            oldest = pending_status.pop_front();
            check_field("line_out", RX_DATA_W'(oldest.line_out), RX_DATA_W'(rsp_line_out));
            check_field("tx_busy", RX_DATA_W'(oldest.tx_busy), RX_DATA_W'(rsp_tx_busy));
            check_field("rx_valid", RX_DATA_W'(oldest.rx_valid), RX_DATA_W'(rsp_rx_valid));
            check_field("rx_data", oldest.rx_data, rsp_rx_data);
            check_field("rx_frame_error", RX_DATA_W'(oldest.frame_error),
                        RX_DATA_W'(rsp_rx_frame_error));
            check_field("error_latched", RX_DATA_W'(oldest.err_latched),
                        RX_DATA_W'(rsp_error_latched));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
hw/rtl/bst_pkg.sv
hw/rtl/bit_serial_transceiver.sv
tb/bit_serial_transceiver_tb.sv
